>>> src/utf8d_pkg.sv
// utf8d_pkg: types and constants shared by the UTF-8 detector modules.
// Holds the scan phase enum, the per-buffer state struct and the result struct.
// No dependencies.
package utf8d_pkg;

	localparam int CP_W = 21;

	typedef enum logic [1:0] {
		PH_SCAN    = 2'd0,
		PH_COLLECT = 2'd1,
		PH_DONE    = 2'd2
	} phase_t;

	typedef struct packed {
		phase_t            phase;
		logic [1:0]        pending;
		logic [1:0]        seq_len;
		logic [CP_W-1:0]   cp;
	} state_t;

	typedef struct packed {
		logic valid;
		logic verdict;
	} result_t;

	localparam state_t STATE_RESET = '{phase: PH_SCAN, pending: 2'd0, seq_len: 2'd0,
		cp: '0};

	localparam logic [7:0] ASCII_MAX  = 8'h7F;
	localparam logic [7:0] LEAD2_LO   = 8'hC2;
	localparam logic [7:0] LEAD2_HI   = 8'hDF;
	localparam logic [7:0] LEAD3_LO   = 8'hE0;
	localparam logic [7:0] LEAD3_HI   = 8'hEF;
	localparam logic [7:0] LEAD4_LO   = 8'hF0;
	localparam logic [7:0] LEAD4_HI   = 8'hF4;
	localparam logic [1:0] CONT_TAG   = 2'b10;

	localparam logic [1:0] LEN_TWO    = 2'd1;
	localparam logic [1:0] LEN_THREE  = 2'd2;
	localparam logic [1:0] LEN_FOUR   = 2'd3;

	localparam logic [CP_W-1:0]  MIN_THREE = 21'h000800;
	localparam logic [CP_W-1:0]  MIN_FOUR  = 21'h010000;
	localparam logic [CP_W-1:0]  MAX_CP    = 21'h10FFFF;
	localparam logic [CP_W-12:0] SURR_HI   = 10'h01B;

endpackage

>>> src/utf8d_step.sv
// utf8d_step: per-byte next-state and verdict logic of the UTF-8 detector.
// Purely combinational; uses utf8d_pkg.
module utf8d_step
	import utf8d_pkg::*;
(
	input  state_t     st,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output state_t     nxt,
	output result_t    res
);

	logic            cont_ok;
	logic [CP_W-1:0] cp_new;
	logic [1:0]      pend_new;
	logic            judge_ok;
	state_t          done_st;

	assign cont_ok  = (data_byte[7:6] == CONT_TAG);
	assign cp_new   = {st.cp[CP_W-7:0], data_byte[5:0]};
	assign pend_new = st.pending - 2'd1;

	always_comb begin
		case (st.seq_len)
			LEN_THREE: judge_ok = (cp_new >= MIN_THREE) && (cp_new[CP_W-1:11] != SURR_HI);
			LEN_FOUR:  judge_ok = (cp_new >= MIN_FOUR) && (cp_new <= MAX_CP);
			default:   judge_ok = 1'b1;
		endcase
	end

	// next state
	always_comb begin
		nxt     = st;
		done_st = st;
		done_st.phase   = PH_DONE;
		done_st.pending = 2'd0;
		case (st.phase)
			PH_DONE: begin
				if (last_byte) nxt = STATE_RESET;
			end
			PH_COLLECT: begin
				if (last_byte) begin
					nxt = STATE_RESET;
				end else if (!cont_ok) begin
					nxt = done_st;
				end else if (pend_new == 2'd0) begin
					nxt    = done_st;
					nxt.cp = cp_new;
				end else begin
					nxt.cp      = cp_new;
					nxt.pending = pend_new;
				end
			end
			default: begin
				// scanning; the unused phase code lands here too
				if (last_byte) begin
					nxt = STATE_RESET;
				end else if (data_byte >= LEAD2_LO && data_byte <= LEAD2_HI) begin
					nxt.phase   = PH_COLLECT;
					nxt.seq_len = LEN_TWO;
					nxt.pending = LEN_TWO;
					nxt.cp      = '0;
				end else if (data_byte >= LEAD3_LO && data_byte <= LEAD3_HI) begin
					nxt.phase   = PH_COLLECT;
					nxt.seq_len = LEN_THREE;
					nxt.pending = LEN_THREE;
					nxt.cp      = {{(CP_W-4){1'b0}}, data_byte[3:0]};
				end else if (data_byte >= LEAD4_LO && data_byte <= LEAD4_HI) begin
					nxt.phase   = PH_COLLECT;
					nxt.seq_len = LEN_FOUR;
					nxt.pending = LEN_FOUR;
					nxt.cp      = {{(CP_W-3){1'b0}}, data_byte[2:0]};
				end
			end
		endcase
	end

	// verdict
	always_comb begin
		res = '0;
		case (st.phase)
			PH_DONE: res = '0;
			PH_COLLECT: begin
				res.valid   = !cont_ok || (pend_new == 2'd0) || last_byte;
				res.verdict = cont_ok && (pend_new == 2'd0) && judge_ok;
			end
			default: begin
				res.valid   = last_byte;
				res.verdict = 1'b0;
			end
		endcase
	end

endmodule

>>> src/utf8_encoding_detector_core.sv
//  channel | signals                      | moves
//  --------+------------------------------+-------------------------------
//  in      | in_valid, in_stall           | data_byte, last_byte
//  out     | out_valid, out_stall         | is_utf8 (at most one per buffer)
//
// One byte per clock sustained, unless out_stall holds a full result register.
// From the input register, the step logic updates the scan state and may load the result register.
// At most one verdict per buffer; the last byte always returns the scan to idle.
// in_stall rises only while the result register is full and out_stall is high.
// arst_n clears the scan state and both valid flags.
module utf8_encoding_detector_core
	import utf8d_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       is_utf8
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	state_t     state_q;
	state_t     state_nxt;
	result_t    res;
	logic       out_valid_q;
	logic       is_utf8_q;
	logic       advance;

	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign is_utf8   = is_utf8_q;

	utf8d_step u_step (
		.st        (state_q),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.nxt       (state_nxt),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			state_q     <= STATE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall) valid_s1 <= in_valid;
			if (advance) begin
				out_valid_q <= valid_s1 && res.valid;
				if (valid_s1) state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
		if (advance && valid_s1 && res.valid) is_utf8_q <= res.verdict;
	end

endmodule

>>> src/utf8d_checker.sv
// utf8d_checker: port-level assertions for the UTF-8 detector, bound to the top.
// Sees only the ports of utf8_encoding_detector_core.
module utf8d_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic is_utf8
);

	// a held result keeps its verdict
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(is_utf8))
		else $error("stalled result changed");

	// the input side is held back only by a full result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

	// with the result register empty, the next item is always taken
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while output empty");

	// a result taken frees the input side at once
	a_take_frees: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |-> !in_stall)
		else $error("input stalled while result taken");

	// a fresh result needs an item accepted earlier through the input register
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid ##1 out_valid |-> $past(in_valid && !in_stall, 2))
		else $error("result without an accepted item");

endmodule

bind utf8_encoding_detector_core utf8d_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.is_utf8   (is_utf8)
);

>>> tb/tb_utf8_encoding_detector_core.sv
// tb_utf8_encoding_detector_core: self-checking bench for the UTF-8 detector core.
// Predicts one verdict per buffer and checks it against the block's result port.
// Depends on utf8d_pkg and utf8_encoding_detector_core.
`timescale 1ns / 100ps

module tb_utf8_encoding_detector_core;
	import utf8d_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS = 400;
	localparam int MAX_REPORTS = 10;

	// Tracks the scan state of the current buffer and the verdicts still owed.
	class verdict_scoreboard;
		phase_t          phase;
		logic [1:0]      pending;
		logic [1:0]      seq_len;
		logic [CP_W-1:0] cp;
		bit              owed_verdicts[$];
		int              errors;

		function new();
			errors = 0;
			clear_scan();
		endfunction

		function void clear_scan();
			phase = PH_SCAN;
			pending = 2'd0;
			seq_len = 2'd0;
			cp = '0;
		endfunction

		function int outstanding();
			return owed_verdicts.size();
		endfunction

		function void report(string what);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("[%0t] %s", $realtime, what);
		endfunction

		// Overlong, surrogate and out-of-range checks on a completed sequence.
		function bit sequence_ok();
			if (seq_len == LEN_THREE) begin
				if (cp < MIN_THREE)
					return 1'b0;
				if (cp[CP_W-1:11] == SURR_HI)
					return 1'b0;
			end else if (seq_len == LEN_FOUR) begin
				if (cp < MIN_FOUR || cp > MAX_CP)
					return 1'b0;
			end
			return 1'b1;
		endfunction

		function void note_byte(logic [7:0] b, logic last);
			bit has_verdict;
			bit verdict;
			has_verdict = 1'b0;
			verdict = 1'b0;
			case (phase)
				PH_DONE: begin
					if (last)
						clear_scan();
				end
				PH_COLLECT: begin
					if (b[7:6] != CONT_TAG) begin
						has_verdict = 1'b1;
					end else begin
						cp = {cp[CP_W-7:0], b[5:0]};
						pending = pending - 2'd1;
						if (pending == 2'd0) begin
							has_verdict = 1'b1;
							verdict = sequence_ok();
						end else if (last) begin
							has_verdict = 1'b1;
						end
					end
				end
				default: begin
					// scanning; the unused phase code behaves the same
					if (last) begin
						has_verdict = 1'b1;
					end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
						seq_len = LEN_TWO;
						cp = '0;
					end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
						seq_len = LEN_THREE;
						cp = {{(CP_W-4){1'b0}}, b[3:0]};
					end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
						seq_len = LEN_FOUR;
						cp = {{(CP_W-3){1'b0}}, b[2:0]};
					end
					if (!last && b > ASCII_MAX && b >= LEAD2_LO && b <= LEAD4_HI) begin
						pending = seq_len;
						phase = PH_COLLECT;
					end
				end
			endcase
			if (has_verdict) begin
				owed_verdicts.push_back(verdict);
				if (last) begin
					clear_scan();
				end else begin
					phase = PH_DONE;
					pending = 2'd0;
				end
			end
		endfunction

		function void check_verdict(logic got);
			bit want;
			if (owed_verdicts.size() == 0) begin
				report($sformatf("unexpected verdict is_utf8=%0b", got));
				return;
			end
			want = owed_verdicts.pop_front();
			if (got !== want)
				report($sformatf("verdict mismatch: expected is_utf8=%0b, got %0b", want, got));
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] data_byte = 8'h00;
	logic       last_byte = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       is_utf8;

	verdict_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int items_sent = 0;
	int cycles = 0;

	utf8_encoding_detector_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.is_utf8   (is_utf8)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_utf8_encoding_detector_core: done, errors");
			$finish;
		end
	end

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < recv_idle_pct);

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			sb.check_verdict(is_utf8);

	// Drive one item, with random gaps ahead of it, and hold it until accepted.
	task automatic send_item(logic [7:0] b, logic last);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			data_byte <= 8'($urandom);
			last_byte <= 1'($urandom);
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= last;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_byte(b, last);
		items_sent++;
	endtask

	task automatic go_quiet();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.outstanding() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly well-formed sequences with random payload, some noise buffers.
	task automatic random_buffer();
		logic [7:0] bytes[$];
		int n;
		int cls;
		int drop;
		logic [7:0] c;
		bytes = {};
		if ($urandom_range(9) < 3) begin
			n = $urandom_range(1, 6);
			repeat (n) bytes.push_back(8'($urandom));
		end else begin
			n = $urandom_range(0, 2);
			repeat (n) bytes.push_back(8'($urandom_range(0, 8'hC1)));
			cls = $urandom_range(0, 2);
			case (cls)
				0: bytes.push_back(8'($urandom_range(LEAD2_LO, LEAD2_HI)));
				1: bytes.push_back(8'($urandom_range(LEAD3_LO, LEAD3_HI)));
				default: bytes.push_back(8'($urandom_range(LEAD4_LO, LEAD4_HI)));
			endcase
			drop = ($urandom_range(99) < 15) ? $urandom_range(1, cls + 1) : 0;
			repeat (cls + 1 - drop) begin
				c = 8'h80 | 8'($urandom_range(0, 63));
				if ($urandom_range(99) < 12)
					c = 8'($urandom);
				bytes.push_back(c);
			end
			if (drop == 0) begin
				n = $urandom_range(0, 2);
				repeat (n) bytes.push_back(8'($urandom));
			end
		end
		foreach (bytes[i])
			send_item(bytes[i], i == bytes.size() - 1);
	endtask

	task automatic random_phase(int items);
		int stop_at;
		stop_at = items_sent + items;
		while (items_sent < stop_at)
			random_buffer();
		go_quiet();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_item(8'h00, 1'b1);                 // plain byte as whole buffer
		send_item(8'hC2, 1'b1);                 // lead byte that ends the buffer
		send_item(8'hDF, 1'b0);
		send_item(8'hBF, 1'b1);                 // two-byte at the top, verdict on last
		send_item(8'hE0, 1'b0);
		send_item(8'hA0, 1'b0);
		send_item(8'h80, 1'b1);                 // smallest three-byte
		send_item(8'hE0, 1'b0);
		send_item(8'h9F, 1'b0);
		send_item(8'hBF, 1'b1);                 // overlong three-byte
		send_item(8'hED, 1'b0);
		send_item(8'hA0, 1'b0);
		send_item(8'h80, 1'b1);                 // surrogate
		send_item(8'hF4, 1'b0);
		send_item(8'h90, 1'b0);
		send_item(8'h80, 1'b0);
		send_item(8'h80, 1'b1);                 // beyond 10FFFF
		send_item(8'hF4, 1'b0);
		send_item(8'h8F, 1'b0);
		send_item(8'hBF, 1'b0);
		send_item(8'hBF, 1'b1);                 // largest code point
		send_item(8'hC2, 1'b0);
		send_item(8'hC0, 1'b0);                 // bad continuation, verdict early
		send_item(8'h80, 1'b1);                 // ignored after the verdict
		send_item(8'hE1, 1'b0);
		send_item(8'h80, 1'b1);                 // truncated by the end of buffer
		go_quiet();

		send_idle_pct = 34;
		recv_idle_pct = 82;
		random_phase(RANDOM_ITEMS / 3);
		send_idle_pct = 82;
		recv_idle_pct = 34;
		random_phase(RANDOM_ITEMS / 3);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

		if (sb.outstanding() != 0)
			sb.report("verdicts still owed at the end");
		if (sb.errors == 0)
			$display("tb_utf8_encoding_detector_core: done, clean");
		else
			$display("tb_utf8_encoding_detector_core: done, errors");
		$finish;
	end

endmodule

>>> utf8_encoding_detector_core.f
src/utf8d_pkg.sv
src/utf8d_step.sv
src/utf8_encoding_detector_core.sv
src/utf8d_checker.sv
tb/tb_utf8_encoding_detector_core.sv
